>>> src/come_pkg.sv
// ----------------------------------------------------------------------------
// come_pkg
// Shared types and constants for the clock offset median estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package come_pkg;

  // Field widths, fixed by the item format
  localparam int TIME_W     = 62;   // unsigned timestamps
  localparam int RES_W      = 63;   // signed differences and offsets
  localparam int GAP_W      = 64;   // absolute gap between two offsets
  localparam int WS_W       = 4;    // window_size register
  localparam int FILL_OUT_W = 4;    // reported window fill
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 62;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_LIMIT = 2'd1;

  // Register reset values
  localparam logic [WS_W-1:0]   WINDOW_SIZE_RST = 4'd5;
  localparam logic [TIME_W-1:0] DRIFT_LIMIT_RST = 62'd1000000;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the item, form round trip
    logic mid;         // local midpoint
    logic samp;        // offset sample
    logic drop;        // trim window, form drift gap
    logic ins;         // write sample, bump fill, decide alarm
    logic vi_load;     // latch candidate, clear rank
    logic rank_step;   // one rank compare
    logic idx_lt;      // compared entry sits before the candidate
    logic rank_end;    // take candidate if its rank is the median's
    logic out_load;    // move result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full_after;  // window becomes full with this insert
    logic out_free;    // output register can take a result now
  } sts_t;

endpackage

`default_nettype wire

>>> src/come_ctrl.sv
// ----------------------------------------------------------------------------
// come_ctrl
// Sequencer: sample arithmetic steps, window update and rank-count sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module come_ctrl #(
  parameter int WINDOW_MAX = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire                   in_rtt_probe,
  output logic                  in_stall,
  input  wire come_pkg::sts_t   sts,
  input  wire [$clog2(WINDOW_MAX+1)-1:0] fill,
  output come_pkg::cmd_t        cmd,
  output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] rd_idx
);

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W = $clog2(WINDOW_MAX+1);

  typedef enum logic [3:0] {
    S_IDLE, S_MID, S_SAMP, S_DROP, S_INS,
    S_MED, S_LOAD_VI, S_RANK, S_RANK_END, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] i_r, i_nxt;
  logic [SLOT_W-1:0] j_r, j_nxt;
  logic              i_last, j_last;

  assign i_last = (FILL_W'(i_r) + FILL_W'(1)) == fill;
  assign j_last = (FILL_W'(j_r) + FILL_W'(1)) == fill;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cmd       = '0;
    rd_idx    = i_r;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = in_rtt_probe ? S_DONE : S_MID;
        end
      end
      S_MID: begin
        cmd.mid   = 1'b1;
        state_nxt = S_SAMP;
      end
      S_SAMP: begin
        cmd.samp  = 1'b1;
        state_nxt = S_DROP;
      end
      S_DROP: begin
        cmd.drop  = 1'b1;
        state_nxt = S_INS;
      end
      S_INS: begin
        cmd.ins = 1'b1;
        i_nxt   = '0;
        state_nxt = sts.full_after ? S_MED : S_DONE;
      end
      S_MED: begin
        rd_idx    = i_r;
        state_nxt = S_LOAD_VI;
      end
      S_LOAD_VI: begin
        cmd.vi_load = 1'b1;
        rd_idx      = '0;
        j_nxt       = '0;
        state_nxt   = S_RANK;
      end
      S_RANK: begin
        cmd.rank_step = 1'b1;
        cmd.idx_lt    = j_r < i_r;
        rd_idx        = j_r + SLOT_W'(1);
        if (j_last) begin
          state_nxt = S_RANK_END;
        end else begin
          j_nxt = j_r + SLOT_W'(1);
        end
      end
      S_RANK_END: begin
        cmd.rank_end = 1'b1;
        if (i_last) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + SLOT_W'(1);
          state_nxt = S_MED;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/come_dp.sv
// ----------------------------------------------------------------------------
// come_dp
// Datapath: registers, sample arithmetic, window store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module come_dp #(
  parameter int WINDOW_MAX = 8
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // configuration
  input  wire                                   cfg_wr_en,
  input  wire [come_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [come_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  // item fields
  input  wire                                   in_rtt_probe,
  input  wire [come_pkg::TIME_W-1:0]            in_request_time,
  input  wire [come_pkg::TIME_W-1:0]            in_server_send_time,
  input  wire [come_pkg::TIME_W-1:0]            in_receive_time,
  // sequencer link
  input  wire come_pkg::cmd_t                   cmd,
  input  wire [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] rd_idx,
  output come_pkg::sts_t                        sts,
  output logic [$clog2(WINDOW_MAX+1)-1:0]       fill,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [come_pkg::RES_W-1:0]     out_round_trip,
  output logic signed [come_pkg::RES_W-1:0]     out_offset_sample,
  output logic                                  out_drift_alarm,
  output logic                                  out_offset_valid,
  output logic signed [come_pkg::RES_W-1:0]     out_current_offset,
  output logic [come_pkg::FILL_OUT_W-1:0]       out_window_fill
);

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W = $clog2(WINDOW_MAX+1);
  localparam int ADD_W  = FILL_W + 1;
  localparam int EXT_W  = ((FILL_W > come_pkg::WS_W) ? FILL_W : come_pkg::WS_W) + 1;
  localparam int RES_W  = come_pkg::RES_W;
  localparam int GAP_W  = come_pkg::GAP_W;

  // configuration registers
  logic [come_pkg::WS_W-1:0]   ws_r;
  logic [come_pkg::TIME_W-1:0] dl_r;

  // persistent state
  logic [SLOT_W-1:0] oldest_r;
  logic [FILL_W-1:0] fill_r;
  logic signed [RES_W-1:0] set_off_r;
  logic              set_valid_r;

  // per-item working registers
  logic                    probe_r;
  logic [come_pkg::TIME_W-1:0] req_r, srv_r;
  logic signed [RES_W-1:0] rt_r, mid_r, sample_r, vi_r;
  logic [GAP_W-1:0]        gap_r;
  logic                    alarm_r;
  logic [FILL_W-1:0]       rank_r;

  // window store
  logic signed [RES_W-1:0] win_mem [WINDOW_MAX];
  logic signed [RES_W-1:0] rd_data_r;

  // result register
  logic                    out_valid_r;
  logic signed [RES_W-1:0] o_rt_r, o_samp_r, o_cur_r;
  logic                    o_alarm_r, o_oval_r;
  logic [FILL_W-1:0]       o_fill_r;

  // effective window size, clamped to 1..WINDOW_MAX
  logic [FILL_W-1:0] size;
  always_comb begin
    if (ws_r == '0) begin
      size = FILL_W'(1);
    end else if (EXT_W'(ws_r) > EXT_W'(WINDOW_MAX)) begin
      size = FILL_W'(WINDOW_MAX);
    end else begin
      size = FILL_W'(ws_r);
    end
  end

  // circular address arithmetic, sums stay below twice the depth
  logic [ADD_W-1:0] rd_sum, wr_sum, drop_sum;
  logic [SLOT_W-1:0] rd_addr, wr_addr, oldest_drop;
  logic [FILL_W-1:0] drop_cnt;
  always_comb begin
    rd_sum   = ADD_W'(oldest_r) + ADD_W'(rd_idx);
    wr_sum   = ADD_W'(oldest_r) + ADD_W'(fill_r);
    drop_cnt = fill_r - size + FILL_W'(1);
    drop_sum = ADD_W'(oldest_r) + ADD_W'(drop_cnt);
    if (rd_sum >= ADD_W'(WINDOW_MAX)) rd_sum = rd_sum - ADD_W'(WINDOW_MAX);
    if (wr_sum >= ADD_W'(WINDOW_MAX)) wr_sum = wr_sum - ADD_W'(WINDOW_MAX);
    if (drop_sum >= ADD_W'(WINDOW_MAX)) drop_sum = drop_sum - ADD_W'(WINDOW_MAX);
    rd_addr     = SLOT_W'(rd_sum);
    wr_addr     = SLOT_W'(wr_sum);
    oldest_drop = SLOT_W'(drop_sum);
  end

  // round trip halved toward zero: arithmetic shift, plus one when odd and negative
  logic signed [RES_W-1:0] rt_now;
  logic signed [GAP_W-1:0] d_ab, d_ba;
  logic                    rank_hit;
  assign rt_now = $signed({1'b0, in_receive_time}) - $signed({1'b0, in_request_time});
  assign d_ab   = GAP_W'(set_off_r) - GAP_W'(sample_r);
  assign d_ba   = GAP_W'(sample_r) - GAP_W'(set_off_r);
  assign rank_hit = (rd_data_r < vi_r) || ((rd_data_r == vi_r) && cmd.idx_lt);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      win_mem[wr_addr] <= sample_r;
    end
    rd_data_r <= win_mem[rd_addr];
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= come_pkg::WINDOW_SIZE_RST;
      dl_r        <= come_pkg::DRIFT_LIMIT_RST;
      oldest_r    <= '0;
      fill_r      <= '0;
      set_off_r   <= '0;
      set_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          come_pkg::REG_WINDOW_SIZE: ws_r <= cfg_wdata[come_pkg::WS_W-1:0];
          come_pkg::REG_DRIFT_LIMIT: dl_r <= cfg_wdata[come_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
      if (cmd.drop && (fill_r >= size)) begin
        oldest_r <= oldest_drop;
        fill_r   <= size - FILL_W'(1);
      end
      if (cmd.ins) begin
        fill_r <= fill_r + FILL_W'(1);
        if ((fill_r + FILL_W'(1)) == size) set_valid_r <= 1'b1;
      end
      if (cmd.rank_end && (rank_r == (fill_r >> 1))) begin
        set_off_r <= vi_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      probe_r <= in_rtt_probe;
      req_r   <= in_request_time;
      srv_r   <= in_server_send_time;
      rt_r    <= rt_now;
      alarm_r <= 1'b0;
    end
    if (cmd.mid) begin
      mid_r <= $signed({1'b0, req_r}) + (rt_r >>> 1)
             + $signed(RES_W'(rt_r[RES_W-1] & rt_r[0]));
    end
    if (cmd.samp) begin
      sample_r <= $signed({1'b0, srv_r}) - mid_r;
    end
    if (cmd.drop) begin
      gap_r <= d_ab[GAP_W-1] ? d_ba : d_ab;
    end
    if (cmd.ins) begin
      alarm_r <= set_valid_r && (gap_r > GAP_W'(dl_r));
    end
    if (cmd.vi_load) begin
      vi_r   <= rd_data_r;
      rank_r <= '0;
    end
    if (cmd.rank_step && rank_hit) begin
      rank_r <= rank_r + FILL_W'(1);
    end
    if (cmd.out_load) begin
      o_rt_r    <= rt_r;
      o_samp_r  <= probe_r ? '0 : sample_r;
      o_alarm_r <= alarm_r;
      o_oval_r  <= set_valid_r;
      o_cur_r   <= set_off_r;
      o_fill_r  <= fill_r;
    end
  end

  assign sts.full_after = (fill_r + FILL_W'(1)) == size;
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign fill           = fill_r;

  assign out_valid          = out_valid_r;
  assign out_round_trip     = o_rt_r;
  assign out_offset_sample  = o_samp_r;
  assign out_drift_alarm    = o_alarm_r;
  assign out_offset_valid   = o_oval_r;
  assign out_current_offset = o_cur_r;
  assign out_window_fill    = come_pkg::FILL_OUT_W'(o_fill_r);

endmodule

`default_nettype wire

>>> src/clock_offset_median_estimator_core.sv
// ----------------------------------------------------------------------------
// clock_offset_median_estimator_core
// Sliding-median clock offset estimator for timestamped sync replies.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------
//  in_     | in  | in_valid / in_stall    | rtt_probe, request, server, receive
//  out_    | out | out_valid / out_stall  | round trip, sample, alarm, offset
//  cfg_    | in  | cfg_wr_en              | cfg_index, cfg_wdata (no read-back)
//
//  One item at a time. A probe goes from accept straight to the result
//  step; a normal reply runs the midpoint, sample, drop and insert steps;
//  a reply that fills the window also runs a rank-count sweep after insert.
//  The sweep length is set by the single read port of the window store.
//  Synchronous active-low reset returns config registers to their defaults
//  and clears fill, pointer and offset; the window store is not cleared.
//  The output register lets the next item be accepted while a result waits
//  under out_stall; the sequencer holds at its last step until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_offset_median_estimator_core #(
  parameter int WINDOW_MAX = 8   // depth of the window store, 1..64
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // configuration
  input  wire                                cfg_wr_en,
  input  wire [come_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [come_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input items
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_rtt_probe,
  input  wire [come_pkg::TIME_W-1:0]         in_request_time,
  input  wire [come_pkg::TIME_W-1:0]         in_server_send_time,
  input  wire [come_pkg::TIME_W-1:0]         in_receive_time,
  // result items
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [come_pkg::RES_W-1:0]  out_round_trip,
  output logic signed [come_pkg::RES_W-1:0]  out_offset_sample,
  output logic                               out_drift_alarm,
  output logic                               out_offset_valid,
  output logic signed [come_pkg::RES_W-1:0]  out_current_offset,
  output logic [come_pkg::FILL_OUT_W-1:0]    out_window_fill
);

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W = $clog2(WINDOW_MAX+1);

  come_pkg::cmd_t    cmd;
  come_pkg::sts_t    sts;
  logic [SLOT_W-1:0] rd_idx;
  logic [FILL_W-1:0] fill;

  // sequencer: arithmetic steps, window trim/insert, then the median sweep
  come_ctrl #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_rtt_probe (in_rtt_probe),
    .in_stall     (in_stall),
    .sts          (sts),
    .fill         (fill),
    .cmd          (cmd),
    .rd_idx       (rd_idx)
  );

  // datapath: window store, offset state and the output register
  come_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_rtt_probe        (in_rtt_probe),
    .in_request_time     (in_request_time),
    .in_server_send_time (in_server_send_time),
    .in_receive_time     (in_receive_time),
    .cmd                 (cmd),
    .rd_idx              (rd_idx),
    .sts                 (sts),
    .fill                (fill),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_round_trip      (out_round_trip),
    .out_offset_sample   (out_offset_sample),
    .out_drift_alarm     (out_drift_alarm),
    .out_offset_valid    (out_offset_valid),
    .out_current_offset  (out_current_offset),
    .out_window_fill     (out_window_fill)
  );

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clock offset median estimator core.
// Sync replies are driven through the input channel under random gaps and
// random result back-pressure. A scoreboard keeps its own copy of the offset
// window, the median and the drift test. It checks every result, field by
// field, in order. Register settings change between phases, only once the
// core has gone quiet.
// ----------------------------------------------------------------------------

typedef struct {
  bit                        probe;
  bit [come_pkg::TIME_W-1:0] req;
  bit [come_pkg::TIME_W-1:0] srv;
  bit [come_pkg::TIME_W-1:0] rcv;
} reply_t;

typedef struct {
  logic [come_pkg::RES_W-1:0]      rtt;
  logic [come_pkg::RES_W-1:0]      sample;
  logic                            alarm;
  logic                            valid;
  logic [come_pkg::RES_W-1:0]      offset;
  logic [come_pkg::FILL_OUT_W-1:0] fill;
} estimate_t;

class offset_scoreboard;
  localparam int DEPTH = 8;

  bit [come_pkg::WS_W-1:0]   win_size;
  bit [come_pkg::TIME_W-1:0] drift_lim;
  longint                    win [DEPTH];
  int                        oldest;
  int                        fill;
  longint                    held_offset;
  bit                        held_valid;
  estimate_t                 expected_q[$];
  int n_err, n_probe, n_sample, n_alarm, n_median, n_checked;

  function new();
    win_size    = come_pkg::WINDOW_SIZE_RST;
    drift_lim   = come_pkg::DRIFT_LIMIT_RST;
    oldest      = 0;
    fill        = 0;
    held_offset = 0;
    held_valid  = 0;
  endfunction

  function void write_reg(logic [come_pkg::CFG_IDX_W-1:0] idx,
                          logic [come_pkg::CFG_DATA_W-1:0] val);
    if (idx == come_pkg::REG_WINDOW_SIZE) win_size = val[come_pkg::WS_W-1:0];
    else if (idx == come_pkg::REG_DRIFT_LIMIT) drift_lim = val;
  endfunction

  // stable rank: ties are ordered by position in the window
  function longint window_median();
    longint vi, vj, pick;
    int     rank;
    pick = 0;
    for (int i = 0; i < fill; i++) begin
      vi   = win[(oldest + i) % DEPTH];
      rank = 0;
      for (int j = 0; j < fill; j++) begin
        vj = win[(oldest + j) % DEPTH];
        if (vj < vi || (vj == vi && j < i)) rank++;
      end
      if (rank == fill / 2) pick = vi;
    end
    return pick;
  endfunction

  function void note_item(reply_t r);
    estimate_t e;
    longint    q, s, c, rt, smp;
    bit [63:0] gap;
    int        sz, drop;
    q   = r.req;
    s   = r.srv;
    c   = r.rcv;
    rt  = c - q;
    smp = 0;
    e.alarm = 1'b0;
    if (r.probe) begin
      n_probe++;
    end else begin
      n_sample++;
      sz  = (win_size == 0) ? 1 : ((win_size > DEPTH) ? DEPTH : win_size);
      smp = s - (q + rt / 2);
      if (fill >= sz) begin
        drop   = fill - sz + 1;
        oldest = (oldest + drop) % DEPTH;
        fill  -= drop;
      end
      win[(oldest + fill) % DEPTH] = smp;
      fill++;
      gap = (held_offset >= smp) ? held_offset - smp : smp - held_offset;
      if (held_valid && gap > {2'b00, drift_lim}) begin
        e.alarm = 1'b1;
        n_alarm++;
      end
      if (fill == sz) begin
        held_offset = window_median();
        held_valid  = 1'b1;
        n_median++;
      end
    end
    e.rtt    = rt[come_pkg::RES_W-1:0];
    e.sample = smp[come_pkg::RES_W-1:0];
    e.valid  = held_valid;
    e.offset = held_offset[come_pkg::RES_W-1:0];
    e.fill   = fill[come_pkg::FILL_OUT_W-1:0];
    expected_q = {expected_q, e};
  endfunction

  task report(string what, logic [63:0] want, logic [63:0] got);
    n_err++;
    if (n_err <= 40)
      $display("mismatch on result %0d, %s: expected %h, got %h",
               n_checked, what, want, got);
  endtask

  task check_result(estimate_t got);
    estimate_t e;
    n_checked++;
    if (expected_q.size() == 0) begin
      report("result with nothing outstanding", 64'd0, 64'd0);
      return;
    end
    e = expected_q.pop_front();
    if (got.rtt !== e.rtt)       report("round_trip", e.rtt, got.rtt);
    if (got.sample !== e.sample) report("offset_sample", e.sample, got.sample);
    if (got.alarm !== e.alarm)   report("drift_alarm", e.alarm, got.alarm);
    if (got.valid !== e.valid)   report("offset_valid", e.valid, got.valid);
    if (got.offset !== e.offset) report("current_offset", e.offset, got.offset);
    if (got.fill !== e.fill)     report("window_fill", e.fill, got.fill);
  endtask
endclass

module tb;

  localparam bit [come_pkg::TIME_W-1:0] T_MAX = {come_pkg::TIME_W{1'b1}};

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_wr_en;
  logic [come_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [come_pkg::CFG_DATA_W-1:0]     cfg_wdata;
  logic                                in_valid;
  logic                                in_stall;
  logic                                in_rtt_probe;
  logic [come_pkg::TIME_W-1:0]         in_request_time;
  logic [come_pkg::TIME_W-1:0]         in_server_send_time;
  logic [come_pkg::TIME_W-1:0]         in_receive_time;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [come_pkg::RES_W-1:0]   out_round_trip;
  logic signed [come_pkg::RES_W-1:0]   out_offset_sample;
  logic                                out_drift_alarm;
  logic                                out_offset_valid;
  logic signed [come_pkg::RES_W-1:0]   out_current_offset;
  logic [come_pkg::FILL_OUT_W-1:0]     out_window_fill;

  offset_scoreboard sb;

  bit idle_on;    // random gaps on both channels
  int hold_req;   // output hold-off requested by the stimulus, in cycles

  clock_offset_median_estimator_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rtt_probe        (in_rtt_probe),
    .in_request_time     (in_request_time),
    .in_server_send_time (in_server_send_time),
    .in_receive_time     (in_receive_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_round_trip      (out_round_trip),
    .out_offset_sample   (out_offset_sample),
    .out_drift_alarm     (out_drift_alarm),
    .out_offset_valid    (out_offset_valid),
    .out_current_offset  (out_current_offset),
    .out_window_fill     (out_window_fill)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every reply filling an
  // eight-deep window, long stalls on both sides, the hold-off phase).
  initial begin
    #1500000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side. Stall is changed at the falling edge only. A hold-off
  // request is taken over here and counted down locally, so the core backs
  // up while the sender keeps offering items.
  initial begin : result_stall
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 35);
      end
    end
  end

  // Results are taken at the rising edge where valid is high and stall low.
  always @(posedge clk) begin : result_check
    estimate_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.rtt    = out_round_trip;
      got.sample = out_offset_sample;
      got.alarm  = out_drift_alarm;
      got.valid  = out_offset_valid;
      got.offset = out_current_offset;
      got.fill   = out_window_fill;
      sb.check_result(got);
    end
  end

  function automatic bit [come_pkg::TIME_W-1:0] rand62();
    bit [63:0] w;
    w = {$urandom, $urandom};
    return w[come_pkg::TIME_W-1:0];
  endfunction

  // One reply: a small share of probes and of fully random noise, the bulk
  // well-formed around a phase offset with jitter sized against the limit.
  function automatic reply_t make_reply(longint centre, longint jitter);
    reply_t r;
    int     pick;
    longint base, rt, jit;
    pick    = $urandom_range(99);
    r.probe = (pick < 15);
    if (pick < 8 || (pick >= 15 && pick < 27)) begin
      r.req = rand62();
      r.srv = rand62();
      r.rcv = rand62();
    end else begin
      base = longint'(rand62() & 62'h0FFF_FFFF_FFFF_FFFF) + 64'h1000_0000_0000_0000;
      rt   = $urandom_range(4000);
      if ($urandom_range(9) == 0) rt = -rt;   // reply stamped before request
      jit  = longint'($urandom_range(32'(2 * jitter))) - jitter;
      r.req = come_pkg::TIME_W'(base);
      r.rcv = come_pkg::TIME_W'(base + rt);
      r.srv = come_pkg::TIME_W'(base + rt / 2 + centre + jit);
    end
    return r;
  endfunction

  // Offer one item; a held valid keeps its payload until it is taken.
  task automatic send_reply(reply_t r);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_rtt_probe        <= r.probe;
    in_request_time     <= r.req;
    in_server_send_time <= r.srv;
    in_receive_time     <= r.rcv;
    do @(posedge clk); while (in_stall);
    sb.note_item(r);
  endtask

  task automatic send_fields(bit probe, bit [come_pkg::TIME_W-1:0] req,
                             bit [come_pkg::TIME_W-1:0] srv,
                             bit [come_pkg::TIME_W-1:0] rcv);
    reply_t r;
    r.probe = probe;
    r.req   = req;
    r.srv   = srv;
    r.rcv   = rcv;
    send_reply(r);
  endtask

  task automatic write_reg(logic [come_pkg::CFG_IDX_W-1:0] idx,
                           logic [come_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [come_pkg::WS_W-1:0] ws,
                           logic [come_pkg::CFG_DATA_W-1:0] dl,
                           int n, longint jitter, int hold);
    longint centre;
    drain();
    write_reg(come_pkg::REG_WINDOW_SIZE, ws);
    write_reg(come_pkg::REG_DRIFT_LIMIT, dl);
    centre = longint'($signed($urandom)) * 64;
    for (int i = 0; i < n; i++) begin
      if (hold != 0 && i == n / 2) hold_req = hold;
      send_reply(make_reply(centre, jitter));
    end
  endtask

  initial begin : stimulus
    sb                  = new();
    idle_on             = 1'b1;
    hold_req            = 0;
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_valid            = 1'b0;
    in_rtt_probe        = 1'b0;
    in_request_time     = '0;
    in_server_send_time = '0;
    in_receive_time     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset settings (size 5, limit 1e6).
    send_fields(1'b1, '0, rand62(), T_MAX);   // probe, largest positive round trip
    send_fields(1'b1, T_MAX, '0, '0);         // probe, largest negative round trip
    send_fields(1'b0, '0, '0, '0);            // no offset yet: no alarm possible
    send_fields(1'b0, '0, T_MAX, '0);         // largest positive sample
    send_fields(1'b0, T_MAX, '0, T_MAX);      // largest negative sample
    send_fields(1'b0, '0, '0, T_MAX);         // odd round trip halved downward
    send_fields(1'b0, T_MAX, T_MAX, '0);      // odd negative halved toward zero; fills
    send_fields(1'b1, 62'd123, 62'd456, 62'd789); // probe reports unchanged state
    repeat (5) send_fields(1'b0, '0, 62'd1000, '0); // equal samples, stable rank
    send_fields(1'b0, '0, 62'd1001000, '0);   // gap exactly at the limit
    send_fields(1'b0, '0, 62'd1001001, '0);   // one past the limit
    send_fields(1'b0, 62'd1000001, '0, 62'd1000001); // negative side past limit
    send_fields(1'b0, 62'd500, 62'd1500, 62'd503);

    // Random phases; the window is lowered from full more than once, and the
    // out-of-range sizes (0 and 15) are exercised.
    run_phase(4'd1, '0, 60, 40, 0);
    idle_on = 1'b0;                           // long stretch without gaps
    run_phase(4'd8, T_MAX, 120, 1000000, 0);
    idle_on = 1'b1;
    run_phase(4'd3, 62'd200, 100, 300, 300);  // includes the long hold-off
    run_phase(4'd0, 62'd1000, 60, 1500, 0);
    run_phase(4'd15, 62'd5000, 100, 8000, 0);
    run_phase(4'd2, come_pkg::CFG_DATA_W'($urandom_range(3000)), 80, 2000, 0);
    run_phase(4'd6, 62'd1000000, 80, 1500000, 0);
    repeat (3) run_phase(come_pkg::WS_W'($urandom_range(15)),
                         come_pkg::CFG_DATA_W'($urandom_range(20000)), 40, 15000, 0);

    drain();
    repeat (120) @(posedge clk);

    $display("covered %0d replies: %0d probes, %0d samples, %0d drift alarms, %0d medians",
             sb.n_probe + sb.n_sample, sb.n_probe, sb.n_sample, sb.n_alarm,
             sb.n_median);
    $display("window sizes 0..15 incl. shrink from full, limits 0..max, one long hold-off");
    if (sb.n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.n_err);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
